>>> rtl/pfc_pkg.sv
package pfc_pkg;

	// Cache geometry
	localparam int SLOT_COUNT    = 16;
	localparam int MAX_FRAME_LEN = 256;
	localparam int IDX_W         = $clog2(SLOT_COUNT);
	localparam int CNT_W         = $clog2(SLOT_COUNT + 1);
	localparam int LEN_W         = $clog2(MAX_FRAME_LEN + 1);

	// Fixed field widths
	localparam int AGE_W   = 32;
	localparam int SEC_W   = 32;
	localparam int USEC_W  = 20;
	localparam int FLEN_W  = 16;
	localparam int KIND_W  = 2;
	localparam int OSLOT_W = 4;
	localparam int OLEN_W  = 9;
	localparam int OCNT_W  = 5;

	// Operation codes
	localparam logic FUNC_STORE = 1'b0;
	localparam logic FUNC_DRAIN = 1'b1;

	// Result kinds
	localparam logic [KIND_W-1:0] KIND_STORE = 2'd0;
	localparam logic [KIND_W-1:0] KIND_ENTRY = 2'd1;
	localparam logic [KIND_W-1:0] KIND_EMPTY = 2'd2;

	// Word that travels down the cell chain during a scan
	typedef struct packed {
		logic             valid;
		logic             free_found;
		logic [IDX_W-1:0] free_idx;
		logic             norm_found;
		logic [IDX_W-1:0] norm_idx;
		logic [AGE_W-1:0] norm_age;
		logic             prio_found;
		logic [IDX_W-1:0] prio_idx;
		logic [AGE_W-1:0] prio_age;
	} scan_t;

	// Per-slot frame descriptor
	typedef struct packed {
		logic              prio;
		logic [LEN_W-1:0]  len;
		logic [SEC_W-1:0]  sec;
		logic [USEC_W-1:0] usec;
	} entry_t;

	// Slot update broadcast to all cells
	typedef struct packed {
		logic             set;
		logic             clr;
		logic [IDX_W-1:0] idx;
		logic [AGE_W-1:0] age;
		entry_t           data;
	} wr_t;

endpackage

>>> rtl/pfc_cell.sv
module pfc_cell import pfc_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [IDX_W-1:0] cell_idx,
	input  wr_t              wr,
	input  scan_t            scan_in,
	output scan_t            scan_out,
	output entry_t           entry
);

	logic             used_q;
	logic             prio_q;
	logic [AGE_W-1:0] age_q;
	logic [LEN_W-1:0] len_q;
	logic [SEC_W-1:0] sec_q;
	logic [USEC_W-1:0] usec_q;
	scan_t            scan_q;
	scan_t            scan_nx;
	logic             hit;

	assign hit = (wr.idx == cell_idx);

	// Slot control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= 1'b0;
			prio_q <= 1'b0;
			age_q  <= '0;
		end else if (wr.set && hit) begin
			used_q <= 1'b1;
			prio_q <= wr.data.prio;
			age_q  <= wr.age;
		end else if (wr.clr && hit) begin
			used_q <= 1'b0;
		end
	end

	// Slot descriptor, no reset
	always_ff @(posedge clk) begin
		if (wr.set && hit) begin
			len_q  <= wr.data.len;
			sec_q  <= wr.data.sec;
			usec_q <= wr.data.usec;
		end
	end

	// Fold this slot into the passing scan word; strict compare keeps the lower slot on ties
	always_comb begin
		scan_nx = scan_in;
		if (!used_q && !scan_in.free_found) begin
			scan_nx.free_found = 1'b1;
			scan_nx.free_idx   = cell_idx;
		end
		if (used_q && !prio_q && (!scan_in.norm_found || age_q < scan_in.norm_age)) begin
			scan_nx.norm_found = 1'b1;
			scan_nx.norm_idx   = cell_idx;
			scan_nx.norm_age   = age_q;
		end
		if (used_q && prio_q && (!scan_in.prio_found || age_q < scan_in.prio_age)) begin
			scan_nx.prio_found = 1'b1;
			scan_nx.prio_idx   = cell_idx;
			scan_nx.prio_age   = age_q;
		end
	end

	// Hand the scan word to the next cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q <= '0;
		end else begin
			scan_q <= scan_nx;
		end
	end

	assign scan_out = scan_q;
	assign entry    = '{prio: prio_q, len: len_q, sec: sec_q, usec: usec_q};

endmodule

>>> rtl/priority_frame_cache_policy_core.sv
// Two-class frame cache slot manager.
// Input channel (in_valid / in_stall): func 0 stores a frame descriptor, func 1 drains
// the cache. Output channel (out_valid / out_stall) carries one result per store, one per
// drained entry and one for a drain of an empty cache, with last set on the final result
// of each input transaction. The slots live in a chain of SLOT_COUNT cells. A scan word
// enters cell 0 and moves one cell per cycle, picking up the first free slot and the
// oldest slot of each class. A valid store gives its result once its scan is through;
// a rejected store or a drain of an empty cache skips the scan and goes straight to its
// result. A drain runs one scan for each entry it emits, priority entries first, each
// class oldest-first. A new transaction is not taken until the current one is through:
// in_stall is high until the last result of the current transaction is loaded into the
// output register.
// The output register holds a result until it is taken; a stalled receiver delays the
// next result and, during a drain, the next slot release, but the following scan can
// already run.
// Reset empties every slot, clears the age counter and the held count; nothing else
// needs to be swept.
module priority_frame_cache_policy_core import pfc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic              func,
	input  logic              is_priority,
	input  logic [FLEN_W-1:0] frame_len,
	input  logic [SEC_W-1:0]  stamp_sec,
	input  logic [USEC_W-1:0] stamp_usec,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [KIND_W-1:0] kind,
	output logic              accepted,
	output logic [OSLOT_W-1:0] slot_index,
	output logic              evicted,
	output logic [OLEN_W-1:0] out_len,
	output logic [SEC_W-1:0]  out_sec,
	output logic [USEC_W-1:0] out_usec,
	output logic              out_priority,
	output logic [OCNT_W-1:0] entry_count,
	output logic              last
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_RESOLVE
	} state_t;

	state_t           state_q;
	logic             launch_q;
	logic             imm_q;
	logic [CNT_W-1:0] count_q;
	logic [AGE_W-1:0] next_age_q;

	// Captured transaction and scan result
	logic             op_func_q;
	entry_t           op_data_q;
	scan_t            res_q;

	// Output register
	logic              out_valid_q;
	logic [KIND_W-1:0] kind_q;
	logic              accepted_q;
	logic [OSLOT_W-1:0] slot_q;
	logic              evicted_q;
	logic [OLEN_W-1:0] len_q;
	logic [SEC_W-1:0]  sec_q;
	logic [USEC_W-1:0] usec_q;
	logic              prio_q;
	logic [OCNT_W-1:0] count_out_q;
	logic              last_q;

	scan_t            seed;
	scan_t            chain [SLOT_COUNT];
	entry_t           entries [SLOT_COUNT];
	wr_t              wr;
	logic             in_take;
	logic             out_free;
	logic             resolve_go;
	logic             len_ok;
	logic [IDX_W-1:0] st_slot;
	logic [IDX_W-1:0] dr_slot;
	entry_t           dr_entry;

	assign in_stall = (state_q != ST_IDLE);
	assign in_take  = in_valid && !in_stall;
	assign len_ok   = (frame_len != '0) && (frame_len <= FLEN_W'(MAX_FRAME_LEN));
	assign out_free = !out_valid_q || !out_stall;
	assign resolve_go = (state_q == ST_RESOLVE) && out_free;

	// Scan seed
	always_comb begin
		seed       = '0;
		seed.valid = launch_q;
	end

	// Cell chain
	for (genvar i = 0; i < SLOT_COUNT; i++) begin : g_cell
		scan_t cin;
		if (i == 0) begin : g_head
			assign cin = seed;
		end else begin : g_link
			assign cin = chain[i-1];
		end
		pfc_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.cell_idx (IDX_W'(i)),
			.wr       (wr),
			.scan_in  (cin),
			.scan_out (chain[i]),
			.entry    (entries[i])
		);
	end

	// Slot choice from the finished scan
	assign st_slot = res_q.free_found ? res_q.free_idx :
	                 (res_q.norm_found ? res_q.norm_idx : res_q.prio_idx);
	assign dr_slot = res_q.prio_found ? res_q.prio_idx : res_q.norm_idx;

	// Descriptor of the slot being drained
	always_comb begin
		dr_entry = entries[0];
		for (int i = 0; i < SLOT_COUNT; i++) begin
			if (dr_slot == IDX_W'(i)) begin
				dr_entry = entries[i];
			end
		end
	end

	// Slot update broadcast
	always_comb begin
		wr      = '0;
		wr.set  = resolve_go && !imm_q && (op_func_q == FUNC_STORE);
		wr.clr  = resolve_go && !imm_q && (op_func_q == FUNC_DRAIN);
		wr.idx  = (op_func_q == FUNC_STORE) ? st_slot : dr_slot;
		wr.age  = next_age_q;
		wr.data = op_data_q;
	end

	// Transaction capture and scan result, no reset
	always_ff @(posedge clk) begin
		if (in_take) begin
			op_func_q      <= func;
			op_data_q.prio <= is_priority;
			op_data_q.len  <= LEN_W'(frame_len);
			op_data_q.sec  <= stamp_sec;
			op_data_q.usec <= stamp_usec;
		end
		if (state_q == ST_SCAN && chain[SLOT_COUNT-1].valid) begin
			res_q <= chain[SLOT_COUNT-1];
		end
	end

	// Sequencer, counters and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			launch_q    <= 1'b0;
			imm_q       <= 1'b0;
			count_q     <= '0;
			next_age_q  <= '0;
			out_valid_q <= 1'b0;
			kind_q      <= KIND_STORE;
			accepted_q  <= 1'b0;
			slot_q      <= '0;
			evicted_q   <= 1'b0;
			len_q       <= '0;
			sec_q       <= '0;
			usec_q      <= '0;
			prio_q      <= 1'b0;
			count_out_q <= '0;
			last_q      <= 1'b0;
		end else begin
			// launch_q is only ever high in the first cycle of a scan
			if (out_valid_q && !out_stall && !resolve_go) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_take) begin
						if ((func == FUNC_STORE && !len_ok) ||
						    (func == FUNC_DRAIN && count_q == '0)) begin
							imm_q   <= 1'b1;
							state_q <= ST_RESOLVE;
						end else begin
							imm_q    <= 1'b0;
							launch_q <= 1'b1;
							state_q  <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					launch_q <= 1'b0;
					if (chain[SLOT_COUNT-1].valid) begin
						state_q <= ST_RESOLVE;
					end
				end
				ST_RESOLVE: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						if (imm_q) begin
							// Rejected store or drain of an empty cache
							state_q    <= ST_IDLE;
							accepted_q <= 1'b0;
							slot_q     <= '0;
							evicted_q  <= 1'b0;
							len_q      <= '0;
							sec_q      <= '0;
							usec_q     <= '0;
							prio_q     <= 1'b0;
							last_q     <= 1'b1;
							if (op_func_q == FUNC_STORE) begin
								kind_q      <= KIND_STORE;
								count_out_q <= OCNT_W'(count_q);
							end else begin
								kind_q      <= KIND_EMPTY;
								count_out_q <= '0;
							end
						end else if (op_func_q == FUNC_STORE) begin
							// Store into free slot or evict
							state_q    <= ST_IDLE;
							kind_q     <= KIND_STORE;
							accepted_q <= 1'b1;
							slot_q     <= OSLOT_W'(st_slot);
							evicted_q  <= !res_q.free_found;
							len_q      <= '0;
							sec_q      <= '0;
							usec_q     <= '0;
							prio_q     <= 1'b0;
							last_q     <= 1'b1;
							next_age_q <= next_age_q + 1'b1;
							if (res_q.free_found) begin
								count_q     <= CNT_W'(count_q + 1'b1);
								count_out_q <= OCNT_W'(count_q + 1'b1);
							end else begin
								count_out_q <= OCNT_W'(count_q);
							end
						end else begin
							// Release one drained entry
							kind_q      <= KIND_ENTRY;
							accepted_q  <= 1'b0;
							slot_q      <= OSLOT_W'(dr_slot);
							evicted_q   <= 1'b0;
							len_q       <= OLEN_W'(dr_entry.len);
							sec_q       <= dr_entry.sec;
							usec_q      <= dr_entry.usec;
							prio_q      <= dr_entry.prio;
							count_q     <= CNT_W'(count_q - 1'b1);
							count_out_q <= OCNT_W'(count_q - 1'b1);
							last_q      <= (count_q == CNT_W'(1));
							if (count_q == CNT_W'(1)) begin
								state_q <= ST_IDLE;
							end else begin
								launch_q <= 1'b1;
								state_q  <= ST_SCAN;
							end
						end
					end
				end
				default: begin
					launch_q <= 1'b0;
					state_q  <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid    = out_valid_q;
	assign kind         = kind_q;
	assign accepted     = accepted_q;
	assign slot_index   = slot_q;
	assign evicted      = evicted_q;
	assign out_len      = len_q;
	assign out_sec      = sec_q;
	assign out_usec     = usec_q;
	assign out_priority = prio_q;
	assign entry_count  = count_out_q;
	assign last         = last_q;

endmodule
